[rtl/tgpc_pkg.sv]
package tgpc_pkg;

    localparam int COORD_W  = 14;
    localparam int EDGE_W   = 15;
    localparam int PROD_W   = 30;
    localparam int CROSS_W  = 31;
    localparam int SUM_W    = 33;
    localparam int IDX_W    = 8;
    localparam int COUNT_W  = 14;

    // Grid spacing and clamp limits, in hundredths and in grid indexes.
    localparam int GRID_STEP    = 100;
    localparam int GRID_LO_IDX  = 1;
    localparam int GRID_HI_IDX  = 99;

    // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for every 14-bit v.
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;
    localparam int RECIP_PROD_W = 27;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [CROSS_W-1:0]        mag_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } verts_t;

    typedef struct packed {
        verts_t v;
        edge_t  abx;
        edge_t  aby;
        edge_t  bcx;
        edge_t  bcy;
        edge_t  cax;
        edge_t  cay;
        mag_t   twice_area;
    } tri_t;

    typedef struct packed {
        logic   valid;
        logic   empty;
        coord_t x_lo;
        coord_t x_hi;
        coord_t y_lo;
        coord_t y_hi;
        tri_t   tri_info;
    } setup_t;

    typedef struct packed {
        logic   valid;
        logic   pt;
        logic   last;
        coord_t px;
        coord_t py;
    } slot_t;

    typedef enum logic {
        SCAN_IDLE,
        SCAN_RUN
    } scan_state_t;

endpackage

[rtl/tgpc_setup.sv]
module tgpc_setup (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  tgpc_pkg::verts_t in_verts,
    output tgpc_pkg::setup_t setup
);
    import tgpc_pkg::*;

    // Stage 1: bounding box and edge vectors.
    logic   s1_valid_reg;
    tri_t   s1_tri_reg;
    coord_t s1_minx_reg, s1_maxx_reg, s1_miny_reg, s1_maxy_reg;
    // Stage 2: grid quotients and area products.
    logic   s2_valid_reg;
    tri_t   s2_tri_reg;
    coord_t s2_minx_reg, s2_maxx_reg, s2_miny_reg, s2_maxy_reg;
    idx_t   s2_qminx_reg, s2_qmaxx_reg, s2_qminy_reg, s2_qmaxy_reg;
    prod_t  s2_pa_reg, s2_pb_reg;
    // Stage 3: clamped grid indexes and twice the area.
    logic   s3_valid_reg;
    tri_t   s3_tri_reg;
    idx_t   s3_xlo_reg, s3_xhi_reg, s3_ylo_reg, s3_yhi_reg;
    logic   s3_empty_reg;
    // Stage 4: box corners back in hundredths.
    logic   s4_valid_reg;
    logic   s4_empty_reg;
    coord_t s4_xlo_reg, s4_xhi_reg, s4_ylo_reg, s4_yhi_reg;
    tri_t   s4_tri_reg;

    function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
        coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
        coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic edge_t sub_edge(coord_t p, coord_t q);
        return $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    function automatic idx_t div100(coord_t v);
        logic [RECIP_PROD_W-1:0] m;
        m = RECIP_PROD_W'(v) * RECIP_PROD_W'(RECIP_100);
        return m[RECIP_SHIFT +: IDX_W];
    endfunction

    // Ceiling to the grid, at least the first grid line.
    function automatic idx_t idx_up(idx_t q, coord_t v);
        logic [EDGE_W-1:0] back;
        idx_t              up;
        back = EDGE_W'(q) * EDGE_W'(GRID_STEP);
        up   = (back != {1'b0, v}) ? q + 1'b1 : q;
        return (up < IDX_W'(GRID_LO_IDX)) ? IDX_W'(GRID_LO_IDX) : up;
    endfunction

    function automatic idx_t idx_down(idx_t q);
        return (q > IDX_W'(GRID_HI_IDX)) ? IDX_W'(GRID_HI_IDX) : q;
    endfunction

    function automatic coord_t idx_coord(idx_t q);
        logic [EDGE_W-1:0] c;
        c = EDGE_W'(q) * EDGE_W'(GRID_STEP);
        return c[COORD_W-1:0];
    endfunction

    function automatic mag_t abs_cross(prod_t p, prod_t q);
        logic signed [CROSS_W-1:0] d;
        d = CROSS_W'(p) - CROSS_W'(q);
        return d[CROSS_W-1] ? mag_t'(-d) : mag_t'(d);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_tri_reg.v          <= in_verts;
        s1_tri_reg.abx        <= sub_edge(in_verts.bx, in_verts.ax);
        s1_tri_reg.aby        <= sub_edge(in_verts.by, in_verts.ay);
        s1_tri_reg.bcx        <= sub_edge(in_verts.cx, in_verts.bx);
        s1_tri_reg.bcy        <= sub_edge(in_verts.cy, in_verts.by);
        s1_tri_reg.cax        <= sub_edge(in_verts.ax, in_verts.cx);
        s1_tri_reg.cay        <= sub_edge(in_verts.ay, in_verts.cy);
        s1_tri_reg.twice_area <= '0;
        s1_minx_reg <= min3(in_verts.ax, in_verts.bx, in_verts.cx);
        s1_maxx_reg <= max3(in_verts.ax, in_verts.bx, in_verts.cx);
        s1_miny_reg <= min3(in_verts.ay, in_verts.by, in_verts.cy);
        s1_maxy_reg <= max3(in_verts.ay, in_verts.by, in_verts.cy);

        s2_tri_reg   <= s1_tri_reg;
        s2_minx_reg  <= s1_minx_reg;
        s2_maxx_reg  <= s1_maxx_reg;
        s2_miny_reg  <= s1_miny_reg;
        s2_maxy_reg  <= s1_maxy_reg;
        s2_qminx_reg <= div100(s1_minx_reg);
        s2_qmaxx_reg <= div100(s1_maxx_reg);
        s2_qminy_reg <= div100(s1_miny_reg);
        s2_qmaxy_reg <= div100(s1_maxy_reg);
        s2_pa_reg    <= s1_tri_reg.abx * s1_tri_reg.bcy;
        s2_pb_reg    <= s1_tri_reg.aby * s1_tri_reg.bcx;

        s3_tri_reg.v          <= s2_tri_reg.v;
        s3_tri_reg.abx        <= s2_tri_reg.abx;
        s3_tri_reg.aby        <= s2_tri_reg.aby;
        s3_tri_reg.bcx        <= s2_tri_reg.bcx;
        s3_tri_reg.bcy        <= s2_tri_reg.bcy;
        s3_tri_reg.cax        <= s2_tri_reg.cax;
        s3_tri_reg.cay        <= s2_tri_reg.cay;
        s3_tri_reg.twice_area <= abs_cross(s2_pa_reg, s2_pb_reg);
        s3_xlo_reg <= idx_up(s2_qminx_reg, s2_minx_reg);
        s3_ylo_reg <= idx_up(s2_qminy_reg, s2_miny_reg);
        s3_xhi_reg <= idx_down(s2_qmaxx_reg);
        s3_yhi_reg <= idx_down(s2_qmaxy_reg);
        s3_empty_reg <= (idx_up(s2_qminx_reg, s2_minx_reg) > idx_down(s2_qmaxx_reg))
                     || (idx_up(s2_qminy_reg, s2_miny_reg) > idx_down(s2_qmaxy_reg));

        s4_empty_reg <= s3_empty_reg;
        s4_xlo_reg   <= idx_coord(s3_xlo_reg);
        s4_xhi_reg   <= idx_coord(s3_xhi_reg);
        s4_ylo_reg   <= idx_coord(s3_ylo_reg);
        s4_yhi_reg   <= idx_coord(s3_yhi_reg);
        s4_tri_reg   <= s3_tri_reg;
    end

    always_comb begin
        setup.valid    = s4_valid_reg;
        setup.empty    = s4_empty_reg;
        setup.x_lo     = s4_xlo_reg;
        setup.x_hi     = s4_xhi_reg;
        setup.y_lo     = s4_ylo_reg;
        setup.y_hi     = s4_yhi_reg;
        setup.tri_info = s4_tri_reg;
    end

endmodule

[rtl/tgpc_scan.sv]
module tgpc_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  tgpc_pkg::setup_t setup,
    output tgpc_pkg::slot_t  slot,
    output tgpc_pkg::tri_t   tri_info
);
    import tgpc_pkg::*;

    scan_state_t state_reg, state_next;
    logic        empty_reg, empty_next;
    coord_t      px_reg, px_next;
    coord_t      py_reg, py_next;
    coord_t      x_lo_reg, x_lo_next;
    coord_t      x_hi_reg, x_hi_next;
    coord_t      y_hi_reg, y_hi_next;
    tri_t        tri_reg, tri_next;
    logic        at_end;

    assign at_end = (px_reg == x_hi_reg) && (py_reg == y_hi_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_IDLE;
            empty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        x_lo_reg <= x_lo_next;
        x_hi_reg <= x_hi_next;
        y_hi_reg <= y_hi_next;
        tri_reg  <= tri_next;
    end

    always_comb begin
        state_next = state_reg;
        empty_next = 1'b0;
        px_next    = px_reg;
        py_next    = py_reg;
        x_lo_next  = x_lo_reg;
        x_hi_next  = x_hi_reg;
        y_hi_next  = y_hi_reg;
        tri_next   = tri_reg;
        case (state_reg)
            SCAN_IDLE: begin
                if (setup.valid) begin
                    tri_next  = setup.tri_info;
                    px_next   = setup.x_lo;
                    py_next   = setup.y_lo;
                    x_lo_next = setup.x_lo;
                    x_hi_next = setup.x_hi;
                    y_hi_next = setup.y_hi;
                    if (setup.empty) begin
                        empty_next = 1'b1;
                    end else begin
                        state_next = SCAN_RUN;
                    end
                end
            end
            SCAN_RUN: begin
                if (at_end) begin
                    state_next = SCAN_IDLE;
                end else if (px_reg == x_hi_reg) begin
                    px_next = x_lo_reg;
                    py_next = py_reg + COORD_W'(GRID_STEP);
                end else begin
                    px_next = px_reg + COORD_W'(GRID_STEP);
                end
            end
            default: begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    // An empty box still sends one closing slot so the count comes out as zero.
    always_comb begin
        slot.valid = (state_reg == SCAN_RUN) || empty_reg;
        slot.pt    = (state_reg == SCAN_RUN);
        slot.last  = empty_reg || at_end;
        slot.px    = px_reg;
        slot.py    = py_reg;
    end

    assign tri_info = tri_reg;

endmodule

[rtl/tgpc_test.sv]
module tgpc_test (
    input  logic              aclk,
    input  logic              aresetn,
    input  tgpc_pkg::slot_t   slot,
    input  tgpc_pkg::tri_t    tri_info,
    input  logic              ack,
    output logic              done,
    output tgpc_pkg::count_t  result
);
    import tgpc_pkg::*;

    logic   t1_valid_reg, t1_pt_reg, t1_last_reg;
    edge_t  dax_reg, day_reg, dbx_reg, dby_reg, dcx_reg, dcy_reg;
    logic   t2_valid_reg, t2_pt_reg, t2_last_reg;
    prod_t  m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic   t3_valid_reg, t3_pt_reg, t3_last_reg;
    mag_t   e0_reg, e1_reg, e2_reg;
    logic   t4_valid_reg, t4_last_reg, t4_hit_reg;
    logic [SUM_W-1:0] sum;
    count_t count_reg, count_next;
    logic   done_reg;
    count_t result_reg;

    function automatic edge_t sub_edge(coord_t p, coord_t q);
        return $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    function automatic mag_t abs_cross(prod_t p, prod_t q);
        logic signed [CROSS_W-1:0] d;
        d = CROSS_W'(p) - CROSS_W'(q);
        return d[CROSS_W-1] ? mag_t'(-d) : mag_t'(d);
    endfunction

    assign sum = SUM_W'(e0_reg) + SUM_W'(e1_reg) + SUM_W'(e2_reg);
    assign count_next = count_reg + COUNT_W'(t4_hit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end else begin
            t1_valid_reg <= slot.valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
            if (t4_valid_reg) begin
                if (t4_last_reg) begin
                    count_reg <= '0;
                    done_reg  <= 1'b1;
                end else begin
                    count_reg <= count_next;
                end
            end else if (ack) begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t1_pt_reg   <= slot.pt;
        t1_last_reg <= slot.last;
        dax_reg <= sub_edge(tri_info.v.ax, slot.px);
        day_reg <= sub_edge(tri_info.v.ay, slot.py);
        dbx_reg <= sub_edge(tri_info.v.bx, slot.px);
        dby_reg <= sub_edge(tri_info.v.by, slot.py);
        dcx_reg <= sub_edge(tri_info.v.cx, slot.px);
        dcy_reg <= sub_edge(tri_info.v.cy, slot.py);

        t2_pt_reg   <= t1_pt_reg;
        t2_last_reg <= t1_last_reg;
        m0_reg <= dax_reg * tri_info.aby;
        m1_reg <= day_reg * tri_info.abx;
        m2_reg <= dbx_reg * tri_info.bcy;
        m3_reg <= dby_reg * tri_info.bcx;
        m4_reg <= dcx_reg * tri_info.cay;
        m5_reg <= dcy_reg * tri_info.cax;

        t3_pt_reg   <= t2_pt_reg;
        t3_last_reg <= t2_last_reg;
        e0_reg <= abs_cross(m0_reg, m1_reg);
        e1_reg <= abs_cross(m2_reg, m3_reg);
        e2_reg <= abs_cross(m4_reg, m5_reg);

        t4_last_reg <= t3_last_reg;
        t4_hit_reg  <= t3_pt_reg && (sum == SUM_W'(tri_info.twice_area));

        if (t4_valid_reg && t4_last_reg) begin
            result_reg <= count_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/triangle_grid_point_counter.sv]
// Triangle grid point counter.
//
// The slave channel carries one triangle per transfer: three vertices as
// unsigned 14-bit coordinates in hundredths of a unit. The master channel
// returns one transfer per triangle holding the number of grid points (all
// multiples of 100 from 100 to 9900 on both axes) that lie inside the
// triangle or on its edges.
//
// The block works on one triangle at a time. A four-stage setup pipeline
// forms the rounded bounding box and twice the area, then the scan sequencer
// issues one grid point per cycle into a five-stage test pipeline that
// accumulates the count. m_tvalid rises once the last grid point of the
// rounded box (or the one closing slot of an empty box) has left the test
// pipeline, and the next triangle can be taken as soon as the count moves
// into the output register.
//
// s_tready is high whenever no triangle is in progress, so the next triangle
// is taken while the previous count still waits in the output register. If
// the receiver stalls, the finished count holds in the test pipeline until
// the output register frees up. Reset clears control state and m_tvalid.
module triangle_grid_point_counter (
    input  logic        aclk,
    input  logic        aresetn,
    // Fields from bit 0 up: vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
    // vertex_c_x, vertex_c_y (14 bits each), then zero fill to 88 bits.
    input  logic [87:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0 up: inside_count (14 bits), then zero fill to 16 bits.
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import tgpc_pkg::*;

    logic   busy_reg, busy_next;
    logic   m_tvalid_reg, m_tvalid_next;
    count_t count_out_reg;
    logic   s_fire;
    logic   ack;
    verts_t in_verts;
    setup_t setup;
    slot_t  slot;
    tri_t   tri_info;
    logic   done;
    count_t result;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;

    // Unpack the triangle, first field in the lowest bits.
    always_comb begin
        in_verts.ax = s_tdata[0*COORD_W +: COORD_W];
        in_verts.ay = s_tdata[1*COORD_W +: COORD_W];
        in_verts.bx = s_tdata[2*COORD_W +: COORD_W];
        in_verts.by = s_tdata[3*COORD_W +: COORD_W];
        in_verts.cx = s_tdata[4*COORD_W +: COORD_W];
        in_verts.cy = s_tdata[5*COORD_W +: COORD_W];
    end

    tgpc_setup u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_fire),
        .in_verts (in_verts),
        .setup    (setup)
    );

    tgpc_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .setup    (setup),
        .slot     (slot),
        .tri_info (tri_info)
    );

    tgpc_test u_test (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .slot     (slot),
        .tri_info (tri_info),
        .ack      (ack),
        .done     (done),
        .result   (result)
    );

    // The finished count moves into the output register once it is free.
    assign ack = done && (!m_tvalid_reg || m_tready);

    always_comb begin
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        if (s_fire) begin
            busy_next = 1'b1;
        end else if (ack) begin
            busy_next = 1'b0;
        end
        if (ack) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ack) begin
            count_out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, count_out_reg};

endmodule

[bench/tb_triangle_grid_point_counter.sv]
`timescale 1ns / 100ps

// Checks the triangle grid point counter through its two stream channels.
// Triangles go in on the slave side, and each count that comes back on the
// master side is compared with a count worked out here by visiting the grid
// points of the rounded bounding box one at a time.
module tb_triangle_grid_point_counter;

    import tgpc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 60;
    localparam int BURST_ITEMS    = 15;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 50;
    localparam int MAX_REPORTS    = 10;
    // The slowest triangle scans 99 by 99 points; allow several times that.
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int MAX_COORD      = (1 << COORD_W) - 1;
    localparam int GRID_LO        = GRID_LO_IDX * GRID_STEP;
    localparam int GRID_HI        = GRID_HI_IDX * GRID_STEP;

    // Packed so that vertex_a_x lands in the lowest bits of s_tdata.
    typedef struct packed {
        coord_t cy;
        coord_t cx;
        coord_t by;
        coord_t bx;
        coord_t ay;
        coord_t ax;
    } triangle_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [87:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;

    // Counts still owed by the block, oldest first.
    count_t      pending_counts[$];
    int          error_count  = 0;
    int          quiet_cycles = 0;
    // Random gaps on both channels; cleared for the back-to-back stretch.
    bit          idle_enable  = 1'b1;
    // Asks the result side for one long hold-off.
    bit          hold_results = 1'b0;

    triangle_grid_point_counter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction of the count.
    // ------------------------------------------------------------------

    // Low box corner: round up to the grid, then keep it at or above the
    // first grid line.
    function automatic longint snap_up(input longint v);
        longint r;
        r = v % GRID_STEP;
        if (r != 0) begin
            v = v + GRID_STEP - r;
        end
        return (v < GRID_LO) ? GRID_LO : v;
    endfunction

    // High box corner: round down to the grid, then keep it at or below the
    // last grid line.
    function automatic longint snap_down(input longint v);
        v = v - v % GRID_STEP;
        return (v > GRID_HI) ? GRID_HI : v;
    endfunction

    function automatic longint min3(input longint a, input longint b, input longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint max3(input longint a, input longint b, input longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Magnitude of the z component of u x v.
    function automatic longint cross_mag(input longint ux, input longint uy,
                                         input longint vx, input longint vy);
        longint z;
        z = ux * vy - uy * vx;
        return (z < 0) ? -z : z;
    endfunction

    // A grid point is inside or on the triangle exactly when the three
    // sub-triangles it forms with the edges add up to the whole area. With
    // zero area this leaves only points on the segment the vertices span.
    function automatic count_t count_grid_points(input triangle_t t);
        longint      ax, ay, bx, by, cx, cy;
        longint      x_lo, x_hi, y_lo, y_hi;
        longint      abx, aby, bcx, bcy, cax, cay;
        longint      twice_area, sum, px, py;
        int unsigned hits;
        ax = t.ax;  ay = t.ay;
        bx = t.bx;  by = t.by;
        cx = t.cx;  cy = t.cy;
        x_lo = snap_up(min3(ax, bx, cx));
        y_lo = snap_up(min3(ay, by, cy));
        x_hi = snap_down(max3(ax, bx, cx));
        y_hi = snap_down(max3(ay, by, cy));
        abx = bx - ax;  aby = by - ay;
        bcx = cx - bx;  bcy = cy - by;
        cax = ax - cx;  cay = ay - cy;
        twice_area = cross_mag(abx, aby, bcx, bcy);
        hits = 0;
        for (py = y_lo; py <= y_hi; py += GRID_STEP) begin
            for (px = x_lo; px <= x_hi; px += GRID_STEP) begin
                sum = cross_mag(ax - px, ay - py, abx, aby)
                    + cross_mag(bx - px, by - py, bcx, bcy)
                    + cross_mag(cx - px, cy - py, cax, cay);
                if (sum == twice_area) begin
                    hits++;
                end
            end
        end
        return count_t'(hits);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic triangle_t make_triangle(input int ax, input int ay,
                                                input int bx, input int by,
                                                input int cx, input int cy);
        triangle_t t;
        t.ax = coord_t'(ax);  t.ay = coord_t'(ay);
        t.bx = coord_t'(bx);  t.by = coord_t'(by);
        t.cx = coord_t'(cx);  t.cy = coord_t'(cy);
        return t;
    endfunction

    // A coordinate somewhere in [base, base + span], optionally pulled onto
    // the grid so that edges and vertices hit grid points exactly.
    function automatic int pick_coord(input int base, input int span, input bit on_grid);
        int v;
        v = base + $urandom_range(0, span);
        if (v > MAX_COORD) begin
            v = MAX_COORD;
        end
        return on_grid ? (v / GRID_STEP) * GRID_STEP : v;
    endfunction

    // Offers one triangle and returns on the clock edge of its transfer.
    // s_tvalid is left high so that a following call with no gap keeps the
    // channel busy; sender_idle lowers it when the stream pauses.
    task automatic send_triangle(input triangle_t t);
        int gap;
        gap = idle_enable ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'b0, t};
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        pending_counts.push_back(count_grid_points(t));
    endtask

    task automatic sender_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        while (pending_counts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Box extremes, empty boxes, degenerate shapes and points on edges.
    task automatic test_directed_cases();
        // Whole field: the box covers all 99 by 99 grid points.
        send_triangle(make_triangle(0, 0, 10000, 0, 0, 10000));
        // Every coordinate bit set: low corner rounds past the last line.
        send_triangle(make_triangle(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD,
                                    MAX_COORD, MAX_COORD));
        // All zero: the high corner falls below the first grid line.
        send_triangle(make_triangle(0, 0, 0, 0, 0, 0));
        // All three vertices on one grid point, then on one point between.
        send_triangle(make_triangle(500, 500, 500, 500, 500, 500));
        send_triangle(make_triangle(550, 550, 550, 550, 550, 550));
        // Collinear vertices along a diagonal, a full-width row and a column.
        send_triangle(make_triangle(100, 100, 900, 900, 500, 500));
        send_triangle(make_triangle(100, 300, 9900, 300, 5000, 300));
        send_triangle(make_triangle(4200, 150, 4200, 9850, 4200, 2000));
        // Small triangle between grid lines: box is empty after rounding.
        send_triangle(make_triangle(110, 110, 190, 110, 150, 190));
        // Grid-aligned right triangle in both windings: edge points count.
        send_triangle(make_triangle(100, 100, 400, 100, 100, 400));
        send_triangle(make_triangle(100, 100, 100, 400, 400, 100));
        // Low corner clamped up to the first grid line.
        send_triangle(make_triangle(0, 0, 300, 0, 0, 300));
        // High corner clamped down to the last grid line.
        send_triangle(make_triangle(9900, 9900, 10000, 9900, 9900, 10000));
        // Coordinates past 10000 on one axis only.
        send_triangle(make_triangle(10050, 200, MAX_COORD, 500, 12000, 0));
        // Opposite corners of the coordinate range: full box, large right triangle.
        send_triangle(make_triangle(0, MAX_COORD, MAX_COORD, 0, 0, 0));
        // Long thin obtuse triangle crossing many columns of one row band.
        send_triangle(make_triangle(100, 100, 9900, 200, 9800, 300));
        // Off-grid vertices whose edges pass close to grid points.
        send_triangle(make_triangle(1234, 5678, 2345, 6789, 1999, 5001));
        sender_idle();
    endtask

    // Mostly small triangles anywhere on the field, some snapped to the grid,
    // some near or past the far corner, and a few with fully random vertices.
    task automatic test_random_triangles();
        triangle_t t;
        int        kind;
        int        base_x;
        int        base_y;
        int        span;
        bit        on_grid;
        repeat (RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                t = make_triangle($urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                                  $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                                  $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD));
            end else begin
                if (kind <= 2) begin
                    base_x = $urandom_range(9000, MAX_COORD);
                    base_y = $urandom_range(9000, MAX_COORD);
                end else begin
                    base_x = $urandom_range(0, 10000);
                    base_y = $urandom_range(0, 10000);
                end
                span    = $urandom_range(0, 1500);
                on_grid = (kind >= 3 && kind <= 8);
                t = make_triangle(pick_coord(base_x, span, on_grid),
                                  pick_coord(base_y, span, on_grid),
                                  pick_coord(base_x, span, on_grid),
                                  pick_coord(base_y, span, on_grid),
                                  pick_coord(base_x, span, on_grid),
                                  pick_coord(base_y, span, on_grid));
            end
            send_triangle(t);
        end
        sender_idle();
    endtask

    // Small triangles with no gaps on either channel.
    task automatic test_back_to_back();
        int base_x;
        int base_y;
        idle_enable = 1'b0;
        repeat (BURST_ITEMS) begin
            base_x = $urandom_range(0, 10000);
            base_y = $urandom_range(0, 10000);
            send_triangle(make_triangle(pick_coord(base_x, 600, 1'b0),
                                        pick_coord(base_y, 600, 1'b0),
                                        pick_coord(base_x, 600, 1'b1),
                                        pick_coord(base_y, 600, 1'b1),
                                        pick_coord(base_x, 600, 1'b0),
                                        pick_coord(base_y, 600, 1'b0)));
        end
        sender_idle();
        idle_enable = 1'b1;
    endtask

    // The result side holds off for a long stretch while triangles keep
    // coming, so the output register and the test pipeline fill up and s_tready drops.
    // Afterwards the sender waits for every count before it goes on.
    task automatic test_result_backpressure();
        int base_x;
        int base_y;
        wait_for_drain();
        hold_results = 1'b1;
        idle_enable  = 1'b0;
        repeat (8) begin
            base_x = $urandom_range(0, 9000);
            base_y = $urandom_range(0, 9000);
            send_triangle(make_triangle(base_x, base_y, base_x + 500, base_y,
                                        base_x, base_y + 500));
        end
        sender_idle();
        idle_enable = 1'b1;
        wait_for_drain();
        repeat (4) begin
            base_x = $urandom_range(0, 9500);
            base_y = $urandom_range(0, 9500);
            send_triangle(make_triangle(base_x, base_y, base_x + 300, base_y + 250,
                                        base_x + 120, base_y + 400));
        end
        sender_idle();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, the long hold-off on request, and the
    // comparison of each returned count with the oldest one owed.
    // ------------------------------------------------------------------
    initial begin : result_side
        int     stall;
        count_t got;
        count_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                stall = idle_enable ? $urandom_range(0, 3) : 0;
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            // Sample on the falling edge ahead of the edge that completes the transfer.
            do @(negedge aclk); while (!m_tvalid);
            got = m_tdata[COUNT_W-1:0];
            @(posedge aclk);
            if (pending_counts.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result: inside_count=%0d", $realtime, got);
                end
            end else begin
                want = pending_counts.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("[%0t] inside_count mismatch: expected %0d, got %0d",
                                 $realtime, want, got);
                    end
                end
            end
        end
    end

    // Ends the run if neither channel completes a transfer for too long.
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin : run_sequence
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_triangles();
        test_back_to_back();
        test_result_backpressure();

        wait_for_drain();
        // Give a stray extra result time to show up.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
